// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps
// spq_pkg: types and constants for the stable priority queue.
// Used by spq_cell and stable_priority_queue; depends on nothing.
package spq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int OCC_W   = 5;

  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    cmd_t                       cmd;
    logic signed [VALUE_W-1:0]  value;
    logic signed [PRIO_W-1:0]   prio;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  head_value;
    logic signed [PRIO_W-1:0]   head_prio;
    status_t                    status;
    logic [OCC_W-1:0]           occupancy;
  } rsp_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic signed [PRIO_W-1:0]   prio;
  } entry_t;

  typedef struct packed {
    logic    push;
    logic    pop;
    entry_t  entry;
  } cell_ctrl_t;

endpackage

// ===== design/spq_cell.sv =====
`timescale 1ns / 1ps
// spq_cell: one slot of the sorted queue; shifts toward the tail on push and
// toward the head on pop. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int CW    = 5,
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  cell_ctrl_t    ctrl,
  input  logic [CW-1:0] count,
  input  entry_t        left_entry,
  input  logic          left_keep,
  input  entry_t        right_entry,
  output entry_t        entry,
  output logic          keep
);

  logic occupied;

  // an occupied slot whose priority is not below the new one stays in place
  assign occupied = CW'(INDEX) < count;
  assign keep     = occupied && (entry.prio >= ctrl.entry.prio);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (!keep) begin
        entry <= left_keep ? ctrl.entry : left_entry;
      end
    end else if (ctrl.pop) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== design/stable_priority_queue.sv =====
`timescale 1ns / 1ps
// stable_priority_queue: bounded sorted-list priority queue built from a row
// of spq_cell slots. Depends on spq_pkg and spq_cell.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one command item: push,
//   pop or peek. rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one
//   item per command: head value and priority, status and occupancy.
//   Larger priority is served first; equal priorities leave in push order.
// Latency: the response is valid the cycle after the command is accepted.
// Throughput: one command per cycle while each response is taken. Every
//   slot compares its priority with the pushed one in parallel and moves
//   one position in the same cycle, so push and pop do not slow with CAPACITY.
// Stall: the response sits in an output register; req_ready is high while
//   that register is empty or being taken, so a stalled receiver holds off
//   new commands without losing a response.
// Reset: rst (synchronous) empties the queue and drops any pending response.
//   Slot contents are not cleared; slots beyond the count are never read.
// Push into a full queue is dropped with status full; pop or peek on an
//   empty queue returns value -1 with status empty.
module stable_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          fire;
  logic          full;
  logic          empty;
  cell_ctrl_t    ctrl;
  rsp_t          rsp_next;
  entry_t        ent  [CAPACITY];
  logic          keep [CAPACITY];

  assign req_ready = !rsp_valid || rsp_ready;
  assign fire      = req_valid && req_ready;
  assign full      = count == CW'(CAPACITY);
  assign empty     = count == '0;

  assign ctrl.push        = fire && (req.cmd == CMD_PUSH) && !full;
  assign ctrl.pop         = fire && (req.cmd == CMD_POP) && !empty;
  assign ctrl.entry.value = req.value;
  assign ctrl.entry.prio  = req.prio;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    logic   left_k;
    entry_t right_e;
    if (i == 0) begin : g_first
      assign left_e = ctrl.entry;
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_e = ent[i-1];
      assign left_k = keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = ent[i];
    end else begin : g_inner
      assign right_e = ent[i+1];
    end
    spq_cell #(
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .left_entry  (left_e),
      .left_keep   (left_k),
      .right_entry (right_e),
      .entry       (ent[i]),
      .keep        (keep[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    rsp_next.head_value = '0;
    rsp_next.head_prio  = '0;
    rsp_next.status     = ST_OK;
    rsp_next.occupancy  = OCC_W'(count_next);
    case (req.cmd)
      CMD_PUSH: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (empty) begin
          rsp_next.head_value = EMPTY_VALUE;
          rsp_next.status     = ST_EMPTY;
        end else begin
          rsp_next.head_value = ent[0].value;
          rsp_next.head_prio  = ent[0].prio;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("queue count exceeds capacity");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |=> count == $past(count) + 1'b1)
    else $error("push did not advance count");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    fire && empty && (req.cmd == CMD_POP || req.cmd == CMD_PEEK)
    |=> rsp_valid && rsp.status == ST_EMPTY && count == '0)
    else $error("empty pop or peek not reported");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> ent[0].prio >= ent[1].prio)
    else $error("head out of priority order");

  a_occ_match: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp.occupancy == OCC_W'(count))
    else $error("reported occupancy disagrees with count");

endmodule
